### hw/rtl/bqd_pkg.sv
// Shared widths, register indexes and types of the biquad filter core.
// Used by bqd_div and biquad_iir_filter_core; depends on nothing.
package bqd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int ACC_BITS    = 64;

    // Digit-serial multiply: sample operand consumed DIGIT_BITS per cycle
    localparam int DIGIT_BITS     = 4;
    localparam int NUM_DIGITS     = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int MPLIER_BITS    = NUM_DIGITS * DIGIT_BITS;
    localparam int DIGIT_CNT_BITS = $clog2(NUM_DIGITS);
    localparam int NUM_TERMS      = 5;
    localparam int TERM_BITS      = $clog2(NUM_TERMS);

    // Quotient bits developed by the divider; anything larger saturates
    localparam int QUO_BITS     = SAMPLE_BITS + 1;
    localparam int QUO_CNT_BITS = $clog2(QUO_BITS);

    localparam logic [QUO_BITS-1:0] POS_LIM = {2'b00, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [QUO_BITS-1:0] NEG_LIM = {2'b01, {(SAMPLE_BITS-1){1'b0}}};

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_A0 = 3'd5;

    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'd16777216);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic [COEF_BITS-2:0]          divisor_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    typedef struct packed {
        logic    done;
        sample_t sample;
        logic    clipped;
    } div_res_t;

endpackage

### hw/rtl/bqd_div.sv
// Bit-serial divider with saturation: |acc| / a0, truncated toward zero,
// signed and clamped to the sample range. Depends on bqd_pkg.
module bqd_div
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  bqd_pkg::acc_t          acc,
    input  bqd_pkg::divisor_t      a0,
    output bqd_pkg::div_res_t      res
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHK,
        D_ITER,
        D_SAT
    } dstate_t;

    dstate_t                               state_reg;
    logic                                  neg_reg;
    logic                                  big_reg;
    logic [bqd_pkg::ACC_BITS-1:0]          mag_reg;
    logic [bqd_pkg::COEF_BITS-2:0]         rem_reg;
    logic [bqd_pkg::QUO_BITS-1:0]          low_reg;
    logic [bqd_pkg::QUO_BITS-1:0]          quo_reg;
    logic [bqd_pkg::QUO_CNT_BITS-1:0]      cnt_reg;
    bqd_pkg::div_res_t                     res_reg;

    logic [bqd_pkg::ACC_BITS-1:0]          mag_next;
    logic [bqd_pkg::ACC_BITS:0]            lim_w;
    logic                                  mag_big;
    logic [bqd_pkg::COEF_BITS-1:0]         trial;
    logic [bqd_pkg::COEF_BITS-1:0]         trial_sub;
    logic                                  trial_ge;
    logic [bqd_pkg::QUO_BITS-1:0]          quo_neg;
    bqd_pkg::div_res_t                     res_next;

    always_comb
    begin
        mag_next = acc[bqd_pkg::ACC_BITS-1]
                 ? ($unsigned(bqd_pkg::ACC_BITS'(0)) - $unsigned(acc))
                 : $unsigned(acc);
    end

    // Quotient needs more than QUO_BITS bits when mag >= a0 * 2^QUO_BITS
    assign lim_w    = (bqd_pkg::ACC_BITS+1)'({a0, {bqd_pkg::QUO_BITS{1'b0}}});
    assign mag_big  = ({1'b0, mag_reg} >= lim_w);

    assign trial     = {rem_reg, low_reg[bqd_pkg::QUO_BITS-1]};
    assign trial_ge  = (trial >= {1'b0, a0});
    assign trial_sub = trial - {1'b0, a0};
    assign quo_neg   = bqd_pkg::QUO_BITS'(0) - quo_reg;

    always_comb
    begin
        res_next.done = 1'b1;
        if (neg_reg)
        begin
            if (big_reg || (quo_reg > bqd_pkg::NEG_LIM))
            begin
                res_next.sample  = bqd_pkg::NEG_LIM[bqd_pkg::SAMPLE_BITS-1:0];
                res_next.clipped = 1'b1;
            end
            else
            begin
                res_next.sample  = quo_neg[bqd_pkg::SAMPLE_BITS-1:0];
                res_next.clipped = 1'b0;
            end
        end
        else
        begin
            if (big_reg || (quo_reg > bqd_pkg::POS_LIM))
            begin
                res_next.sample  = bqd_pkg::POS_LIM[bqd_pkg::SAMPLE_BITS-1:0];
                res_next.clipped = 1'b1;
            end
            else
            begin
                res_next.sample  = quo_reg[bqd_pkg::SAMPLE_BITS-1:0];
                res_next.clipped = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            neg_reg   <= 1'b0;
            big_reg   <= 1'b0;
            mag_reg   <= '0;
            rem_reg   <= '0;
            low_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            res_reg.done <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg   <= acc[bqd_pkg::ACC_BITS-1];
                        mag_reg   <= mag_next;
                        state_reg <= D_CHK;
                    end
                end
                D_CHK:
                begin
                    rem_reg <= mag_reg[bqd_pkg::QUO_BITS +: (bqd_pkg::COEF_BITS-1)];
                    low_reg <= mag_reg[bqd_pkg::QUO_BITS-1:0];
                    quo_reg <= '0;
                    cnt_reg <= '0;
                    // Zero sum gives zero even with a zero divisor
                    if (mag_reg == '0)
                    begin
                        big_reg   <= 1'b0;
                        state_reg <= D_SAT;
                    end
                    else if (mag_big)
                    begin
                        big_reg   <= 1'b1;
                        state_reg <= D_SAT;
                    end
                    else
                    begin
                        big_reg   <= 1'b0;
                        state_reg <= D_ITER;
                    end
                end
                D_ITER:
                begin
                    rem_reg <= trial_ge ? trial_sub[bqd_pkg::COEF_BITS-2:0]
                                        : trial[bqd_pkg::COEF_BITS-2:0];
                    quo_reg <= {quo_reg[bqd_pkg::QUO_BITS-2:0], trial_ge};
                    low_reg <= {low_reg[bqd_pkg::QUO_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == bqd_pkg::QUO_CNT_BITS'(bqd_pkg::QUO_BITS-1))
                    begin
                        state_reg <= D_SAT;
                    end
                end
                D_SAT:
                begin
                    res_reg   <= res_next;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

### hw/rtl/biquad_iir_filter_core.sv
// Biquad IIR filter core, direct form I, digit-serial multiply-accumulate.
// Each input runs the MAC over all five terms, then bqd_div through its check, its divide steps
// and its saturate state, then FIN; the divide steps are skipped when the sum is zero or the
// quotient overflows. Rate is set by the 4-bit-per-cycle MAC and the one-bit-per-cycle divider.
// Input stalls until FIN hands the result on; a new item is taken while a result waits.
// Reset: histories cleared, coefficients pass-through (b0 = a0 = 1.0). Uses bqd_pkg, bqd_div.
module biquad_iir_filter_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  bqd_pkg::sample_t                      sample_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output bqd_pkg::sample_t                      sample_out,
    output logic                                  clipped,
    input  logic                                  cfg_we,
    input  logic [bqd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [bqd_pkg::COEF_BITS-1:0]         cfg_data
);

    typedef enum logic [1:0] {
        IDLE,
        MAC,
        DIVW,
        FIN
    } state_t;

    localparam logic [bqd_pkg::TERM_BITS-1:0] TERM_X0 = 3'd0;
    localparam logic [bqd_pkg::TERM_BITS-1:0] TERM_X1 = 3'd1;
    localparam logic [bqd_pkg::TERM_BITS-1:0] TERM_X2 = 3'd2;
    localparam logic [bqd_pkg::TERM_BITS-1:0] TERM_Y1 = 3'd3;
    localparam logic [bqd_pkg::TERM_BITS-1:0] TERM_Y2 = 3'd4;

    bqd_pkg::coef_t                            coef_b0_reg;
    bqd_pkg::coef_t                            coef_b1_reg;
    bqd_pkg::coef_t                            coef_b2_reg;
    bqd_pkg::coef_t                            coef_a1_reg;
    bqd_pkg::coef_t                            coef_a2_reg;
    bqd_pkg::divisor_t                         coef_a0_reg;

    state_t                                    state_reg;
    bqd_pkg::sample_t                          x_reg;
    bqd_pkg::sample_t                          in_hist_one_reg;
    bqd_pkg::sample_t                          in_hist_two_reg;
    bqd_pkg::sample_t                          out_hist_one_reg;
    bqd_pkg::sample_t                          out_hist_two_reg;
    logic [bqd_pkg::TERM_BITS-1:0]             term_reg;
    logic [bqd_pkg::DIGIT_CNT_BITS-1:0]        digit_reg;
    bqd_pkg::acc_t                             mcand_reg;
    logic [bqd_pkg::MPLIER_BITS-1:0]           mplier_reg;
    bqd_pkg::acc_t                             acc_reg;
    logic                                      start_reg;
    logic                                      out_valid_reg;
    bqd_pkg::sample_t                          sample_out_reg;
    logic                                      clipped_reg;

    logic [bqd_pkg::TERM_BITS-1:0]             sel_term;
    bqd_pkg::coef_t                            sel_coef;
    bqd_pkg::sample_t                          sel_val;
    logic                                      last_digit;
    logic signed [bqd_pkg::DIGIT_BITS:0]       dig_s;
    bqd_pkg::acc_t                             prod;
    bqd_pkg::acc_t                             acc_next;
    logic                                      slot_free;
    bqd_pkg::div_res_t                         div_res;

    // Operand select for the term about to be loaded
    assign sel_term = (state_reg == IDLE) ? TERM_X0 : (term_reg + 1'b1);

    always_comb
    begin
        unique case (sel_term)
            TERM_X0:
            begin
                sel_coef = coef_b0_reg;
                sel_val  = sample_in;
            end
            TERM_X1:
            begin
                sel_coef = coef_b1_reg;
                sel_val  = in_hist_one_reg;
            end
            TERM_X2:
            begin
                sel_coef = coef_b2_reg;
                sel_val  = in_hist_two_reg;
            end
            TERM_Y1:
            begin
                sel_coef = coef_a1_reg;
                sel_val  = out_hist_one_reg;
            end
            TERM_Y2:
            begin
                sel_coef = coef_a2_reg;
                sel_val  = out_hist_two_reg;
            end
            default:
            begin
                sel_coef = '0;
                sel_val  = '0;
            end
        endcase
    end

    // Lower digits are unsigned; the top digit carries the sample's sign
    assign last_digit = (digit_reg == bqd_pkg::DIGIT_CNT_BITS'(bqd_pkg::NUM_DIGITS-1));
    assign dig_s      = {last_digit & mplier_reg[bqd_pkg::DIGIT_BITS-1],
                         mplier_reg[bqd_pkg::DIGIT_BITS-1:0]};
    assign prod       = mcand_reg * dig_s;
    assign acc_next   = (term_reg >= TERM_Y1) ? (acc_reg - prod) : (acc_reg + prod);

    assign slot_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg <= bqd_pkg::COEF_ONE;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
            coef_a0_reg <= bqd_pkg::COEF_ONE[bqd_pkg::COEF_BITS-2:0];
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bqd_pkg::REG_B0: coef_b0_reg <= cfg_data;
                bqd_pkg::REG_B1: coef_b1_reg <= cfg_data;
                bqd_pkg::REG_B2: coef_b2_reg <= cfg_data;
                bqd_pkg::REG_A1: coef_a1_reg <= cfg_data;
                bqd_pkg::REG_A2: coef_a2_reg <= cfg_data;
                bqd_pkg::REG_A0: coef_a0_reg <= cfg_data[bqd_pkg::COEF_BITS-2:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            x_reg            <= '0;
            in_hist_one_reg  <= '0;
            in_hist_two_reg  <= '0;
            out_hist_one_reg <= '0;
            out_hist_two_reg <= '0;
            term_reg         <= '0;
            digit_reg        <= '0;
            mcand_reg        <= '0;
            mplier_reg       <= '0;
            acc_reg          <= '0;
            start_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            sample_out_reg   <= '0;
            clipped_reg      <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg      <= sample_in;
                        acc_reg    <= '0;
                        term_reg   <= TERM_X0;
                        digit_reg  <= '0;
                        mcand_reg  <= bqd_pkg::ACC_BITS'(sel_coef);
                        mplier_reg <= bqd_pkg::MPLIER_BITS'(sel_val);
                        state_reg  <= MAC;
                    end
                end
                MAC:
                begin
                    acc_reg <= acc_next;
                    if (last_digit)
                    begin
                        if (term_reg == TERM_Y2)
                        begin
                            start_reg <= 1'b1;
                            state_reg <= DIVW;
                        end
                        else
                        begin
                            term_reg   <= sel_term;
                            digit_reg  <= '0;
                            mcand_reg  <= bqd_pkg::ACC_BITS'(sel_coef);
                            mplier_reg <= bqd_pkg::MPLIER_BITS'(sel_val);
                        end
                    end
                    else
                    begin
                        // Advance to the next digit of the sample operand
                        digit_reg  <= digit_reg + 1'b1;
                        mcand_reg  <= mcand_reg <<< bqd_pkg::DIGIT_BITS;
                        mplier_reg <= mplier_reg >> bqd_pkg::DIGIT_BITS;
                    end
                end
                DIVW:
                begin
                    if (div_res.done)
                    begin
                        state_reg <= FIN;
                    end
                end
                FIN:
                begin
                    // Hold until the output register can take the item
                    if (slot_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        sample_out_reg   <= div_res.sample;
                        clipped_reg      <= div_res.clipped;
                        out_hist_two_reg <= out_hist_one_reg;
                        out_hist_one_reg <= div_res.sample;
                        in_hist_two_reg  <= in_hist_one_reg;
                        in_hist_one_reg  <= x_reg;
                        state_reg        <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    bqd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .acc   (acc_reg),
        .a0    (coef_a0_reg),
        .res   (div_res)
    );

    assign in_stall   = (state_reg != IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for biquad_iir_filter_core: a direct form I predictor
// in a small scoreboard class, driven by tasks for samples and coefficients.
// Depends on bqd_pkg and the filter core RTL.
module testbench;

    localparam int NUM_REGS        = 6;
    localparam int NUM_PHASES      = 12;
    localparam int SAMPLES_PER_SET = 108;
    localparam int SETTLE_CYCLES   = 70;
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam logic [bqd_pkg::CFG_IDX_BITS-1:0] IDX_SPARE_LO = bqd_pkg::REG_A0 + 1'b1;
    localparam logic [bqd_pkg::CFG_IDX_BITS-1:0] IDX_SPARE_HI = '1;

    localparam logic [63:0] POS_MAX = (64'd1 << (bqd_pkg::SAMPLE_BITS - 1)) - 64'd1;
    localparam logic [63:0] NEG_MAG = 64'd1 << (bqd_pkg::SAMPLE_BITS - 1);

    typedef logic [bqd_pkg::COEF_BITS-1:0] coef_word_t;
    typedef coef_word_t coef_set_t [NUM_REGS];

    typedef struct packed {
        bqd_pkg::sample_t sample;
        logic             clipped;
    } filtered_t;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BLOCKS} rx_mode_t;

    class biquad_scoreboard;
        bqd_pkg::coef_t    b0, b1, b2, a1, a2;
        bqd_pkg::divisor_t a0;
        bqd_pkg::sample_t  x1, x2, y1, y2;
        filtered_t         expected_q [$];
        int                errors;

        function new();
            b0 = bqd_pkg::COEF_ONE;
            b1 = '0;
            b2 = '0;
            a1 = '0;
            a2 = '0;
            a0 = bqd_pkg::COEF_ONE[bqd_pkg::COEF_BITS-2:0];
            x1 = '0;
            x2 = '0;
            y1 = '0;
            y2 = '0;
            errors = 0;
        endfunction

        function void write_coef(logic [bqd_pkg::CFG_IDX_BITS-1:0] idx, coef_word_t data);
            case (idx)
                bqd_pkg::REG_B0: b0 = data;
                bqd_pkg::REG_B1: b1 = data;
                bqd_pkg::REG_B2: b2 = data;
                bqd_pkg::REG_A1: a1 = data;
                bqd_pkg::REG_A2: a2 = data;
                bqd_pkg::REG_A0: a0 = data[bqd_pkg::COEF_BITS-2:0];
                default: ;
            endcase
        endfunction

        // Run one step of the filter and queue the output it must produce
        function void take_sample(bqd_pkg::sample_t x);
            longint      acc;
            logic [63:0] mag;
            logic [63:0] quo;
            logic        neg;
            filtered_t   r;
            acc = longint'(b0) * longint'(x) + longint'(b1) * longint'(x1)
                + longint'(b2) * longint'(x2) - longint'(a1) * longint'(y1)
                - longint'(a2) * longint'(y2);
            neg = acc[63];
            mag = neg ? -acc : acc;
            if (a0 == '0)
                quo = (mag == '0) ? 64'd0 : '1;
            else
                quo = mag / {33'd0, a0};
            r.clipped = 1'b0;
            if (neg) begin
                if (quo > NEG_MAG) begin
                    quo = NEG_MAG;
                    r.clipped = 1'b1;
                end
                r.sample = bqd_pkg::sample_t'(-quo);
            end
            else begin
                if (quo > POS_MAX) begin
                    quo = POS_MAX;
                    r.clipped = 1'b1;
                end
                r.sample = bqd_pkg::sample_t'(quo);
            end
            y2 = y1;
            y1 = r.sample;
            x2 = x1;
            x1 = x;
            expected_q.push_back(r);
        endfunction

        function void match_output(bqd_pkg::sample_t s, logic c);
            filtered_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected output, sample_out %0d clipped %0b", $time, s, c);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (s !== e.sample) begin
                $display("%0t: sample_out expected %0d actual %0d", $time, e.sample, s);
                errors++;
            end
            if (c !== e.clipped) begin
                $display("%0t: clipped expected %0b actual %0b", $time, e.clipped, c);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                             clk        = 1'b0;
    logic                             rst_n      = 1'b0;
    logic                             in_valid   = 1'b0;
    logic                             in_stall;
    bqd_pkg::sample_t                 sample_in  = '0;
    logic                             out_valid;
    logic                             out_stall  = 1'b0;
    bqd_pkg::sample_t                 sample_out;
    logic                             clipped;
    logic                             cfg_we     = 1'b0;
    logic [bqd_pkg::CFG_IDX_BITS-1:0] cfg_index  = '0;
    coef_word_t                       cfg_data   = '0;

    biquad_scoreboard sb;
    int               quiet_cycles = 0;
    int               burst_left   = 0;
    bit               gaps_on      = 1'b0;
    rx_mode_t         rx_mode      = RX_FREE;
    int               rx_left      = 0;

    biquad_iir_filter_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .clipped    (clipped),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: switch stall pattern after a random interval
    always @(posedge clk)
    begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(50, 300);
        end
        else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:  out_stall <= rx_left[5];
        endcase
    end

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            sb.take_sample(sample_in);
        if (out_valid && !out_stall)
            sb.match_output(sample_out, clipped);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("testbench NOT OK");
        $finish;
    end

    task automatic send_sample(bqd_pkg::sample_t v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 12) : 0;
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        sample_in <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hold off until every queued output has come back, then let the core settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [bqd_pkg::CFG_IDX_BITS-1:0] idx, coef_word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_coef(idx, data);
    endtask

    task automatic program_coefs(coef_set_t v, bit with_spare);
        if (with_spare) begin
            cfg_write(IDX_SPARE_LO, $urandom);
            cfg_write(IDX_SPARE_HI, $urandom);
        end
        for (int i = 0; i < NUM_REGS; i++)
            cfg_write(i[bqd_pkg::CFG_IDX_BITS-1:0], v[i]);
        cfg_we <= 1'b0;
    endtask

    function automatic coef_word_t spread(int half);
        return coef_word_t'(int'($urandom_range(0, 2 * half)) - half);
    endfunction

    function automatic coef_set_t pick_coefs(int mode);
        coef_set_t  v;
        coef_word_t edges [5];
        coef_word_t div_edges [4];
        edges     = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF};
        div_edges = '{32'h1, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        for (int i = 0; i < NUM_REGS; i++) begin
            case (mode)
                0:  // mild filter around unity scale
                    if (i == bqd_pkg::REG_A0)
                        v[i] = bqd_pkg::COEF_ONE + spread(1 << 20);
                    else if (i >= bqd_pkg::REG_A1)
                        v[i] = spread(1 << 23);
                    else
                        v[i] = spread(1 << 24);
                1:
                    v[i] = $urandom;
                2:
                    v[i] = (i == bqd_pkg::REG_A0) ? div_edges[$urandom_range(0, 3)]
                                                  : edges[$urandom_range(0, 4)];
                default:  // small divisor, heavy gain
                    if (i == bqd_pkg::REG_A0)
                        v[i] = $urandom_range(1, 1024);
                    else if (i >= bqd_pkg::REG_A1)
                        v[i] = spread(1 << 12);
                    else
                        v[i] = spread(1 << 16);
            endcase
        end
        return v;
    endfunction

    function automatic bqd_pkg::sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? bqd_pkg::sample_t'(8388607)
                                                 : bqd_pkg::sample_t'(-8388608);
            1:       return bqd_pkg::sample_t'(int'($urandom_range(0, 511)) - 256);
            default: return bqd_pkg::sample_t'($urandom);
        endcase
    endfunction

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass-through from reset: extremes and alternating bit patterns
        gaps_on = 1'b1;
        send_sample(bqd_pkg::sample_t'(0));
        send_sample(bqd_pkg::sample_t'(8388607));
        send_sample(bqd_pkg::sample_t'(-8388608));
        send_sample(bqd_pkg::sample_t'(1));
        send_sample(bqd_pkg::sample_t'(-1));
        send_sample(bqd_pkg::sample_t'(24'h555555));
        send_sample(bqd_pkg::sample_t'(24'hAAAAAA));
        drain();

        // Zero divisor: nonzero sum saturates, zero sum stays zero; spare indexes ignored
        program_coefs('{bqd_pkg::COEF_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        send_sample(bqd_pkg::sample_t'(0));
        send_sample(bqd_pkg::sample_t'(100));
        send_sample(bqd_pkg::sample_t'(-100));
        send_sample(bqd_pkg::sample_t'(0));
        drain();

        // Largest weights; top bit of the divisor write must be dropped
        program_coefs('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b0);
        send_sample(bqd_pkg::sample_t'(8388607));
        send_sample(bqd_pkg::sample_t'(-8388608));
        send_sample(bqd_pkg::sample_t'(8388607));
        send_sample(bqd_pkg::sample_t'(-8388608));
        send_sample(bqd_pkg::sample_t'(0));
        send_sample(bqd_pkg::sample_t'(1));
        drain();

        // Most negative weights over a unit divisor
        program_coefs('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h1}, 1'b0);
        send_sample(bqd_pkg::sample_t'(-8388608));
        send_sample(bqd_pkg::sample_t'(-8388608));
        send_sample(bqd_pkg::sample_t'(8388607));
        send_sample(bqd_pkg::sample_t'(-1));
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            program_coefs(pick_coefs(ph % 4), ph % 2 == 1);
            gaps_on = $urandom_range(0, 2) != 0;
            burst_left = 0;
            for (int n = 0; n < SAMPLES_PER_SET; n++)
                send_sample(pick_sample());
            drain();
        end

        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### sim.f
hw/rtl/bqd_pkg.sv
hw/rtl/bqd_div.sv
hw/rtl/biquad_iir_filter_core.sv
sim/testbench.sv
